// ----- rtl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character helpers shared by the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int unsigned CNT_W  = 6;
   localparam int unsigned IDX_W  = 5;
   localparam int unsigned LINE_W = 16;
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;

   localparam logic [4:0] KIND_IDENT   = 5'd10;
   localparam logic [4:0] KIND_FN      = 5'd11;
   localparam logic [4:0] KIND_STRING  = 5'd15;
   localparam logic [4:0] KIND_INT     = 5'd16;
   localparam logic [4:0] KIND_UNKNOWN = 5'd17;
   localparam logic [4:0] KIND_TAB     = 5'd18;
   localparam logic [4:0] KIND_UNTERM  = 5'd19;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;

   localparam int unsigned NUM_KW = 4;
   localparam logic [CNT_W-1:0] KW_LEN [NUM_KW] = '{6'd2, 6'd6, 6'd3, 6'd6};

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_STRING = 2'd2,
      MODE_INT    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_SINGLE = 2'd1,
      CMD_TEXT   = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]        token_kind;
      logic [LINE_W-1:0] line_number;
      logic [LINE_W-1:0] column_number;
      logic [CNT_W-1:0]  text_length;
      logic [7:0]        text_byte;
      logic [IDX_W-1:0]  text_index;
      logic              text_truncated;
      logic              token_done;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      cmd_op_type op;
      rsp_type    res;
   } cmd_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
   } punct_type;

   function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v);
      return (v == {LINE_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic punct_type punct_lookup(input logic [7:0] c);
      punct_type p;
      p.hit = 1'b1;
      p.kind = 5'd0;
      unique case (c)
         "(":     p.kind = 5'd0;
         ")":     p.kind = 5'd1;
         "{":     p.kind = 5'd2;
         "}":     p.kind = 5'd3;
         "=":     p.kind = 5'd4;
         ":":     p.kind = 5'd5;
         ",":     p.kind = 5'd6;
         ".":     p.kind = 5'd7;
         "<":     p.kind = 5'd8;
         ">":     p.kind = 5'd9;
         default: p.hit = 1'b0;
      endcase
      return p;
   endfunction

   // keywords in order: fn, extern, var, struct
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
      logic [7:0] ch;
      ch = 8'h00;
      unique case ({k, p})
         {2'd0, 3'd0}: ch = "f";
         {2'd0, 3'd1}: ch = "n";
         {2'd1, 3'd0}: ch = "e";
         {2'd1, 3'd1}: ch = "x";
         {2'd1, 3'd2}: ch = "t";
         {2'd1, 3'd3}: ch = "e";
         {2'd1, 3'd4}: ch = "r";
         {2'd1, 3'd5}: ch = "n";
         {2'd2, 3'd0}: ch = "v";
         {2'd2, 3'd1}: ch = "a";
         {2'd2, 3'd2}: ch = "r";
         {2'd3, 3'd0}: ch = "s";
         {2'd3, 3'd1}: ch = "t";
         {2'd3, 3'd2}: ch = "r";
         {2'd3, 3'd3}: ch = "u";
         {2'd3, 3'd4}: ch = "c";
         {2'd3, 3'd5}: ch = "t";
         default:      ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/source_token_lexer.sv -----
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: one source byte per request, tokens out as results.
// ----------------------------------------------------------------------------
// A request is taken only while no commands are pending; the classifier then
// pushes its queued commands (a text append, a token, or a flush at end of
// input) one at a time, so a byte inside an identifier, integer or string holds
// off the next request while its append is pushed, and a space or newline does
// not. The replay unit behind a four-entry command queue writes one buffered
// character per cycle and, unless the result side stalls, replays text at one
// character per result per cycle through a registered buffer read. A result
// passes the command slots, the queue, a staging register and the output register.
// ----------------------------------------------------------------------------
module source_token_lexer import stl_pkg::*; #(
   parameter int unsigned MAX_TEXT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push_valid;
   logic    push_full;
   cmd_type push_data;
   logic    head_valid;
   cmd_type head_data;
   logic    pop;

   stl_front #(.MAX_TEXT(MAX_TEXT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data)
   );

   stl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   stl_back #(.MAX_TEXT(MAX_TEXT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/stl_front.sv -----
// ----------------------------------------------------------------------------
// stl_front
// Classifies each source byte, tracks mode, line and column, and queues
// append and token commands for the replay unit.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; #(
   parameter int unsigned MAX_TEXT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_full,
   output cmd_type push_data
);

   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LINE_W-1:0] col_ff, col_in;
   logic [LINE_W-1:0] scol_ff, scol_in;
   logic [NUM_KW-1:0] kw_ff, kw_in;
   cmd_type           slot_ff [3];
   cmd_type           slot_in [3];
   logic [2:0]        pend_ff, pend_in;
   logic              req_accept;

   function automatic cmd_type make_single(input logic [4:0] kind,
                                           input logic [LINE_W-1:0] line,
                                           input logic [LINE_W-1:0] col,
                                           input logic [CNT_W-1:0] len,
                                           input logic [7:0] byte_val,
                                           input logic trunc);
      cmd_type r;
      r.op = CMD_SINGLE;
      r.res.token_kind = kind;
      r.res.line_number = line;
      r.res.column_number = col;
      r.res.text_length = len;
      r.res.text_byte = byte_val;
      r.res.text_index = '0;
      r.res.text_truncated = trunc;
      r.res.token_done = 1'b1;
      r.res.run_last = 1'b0;
      return r;
   endfunction

   function automatic cmd_type make_emit(input logic [4:0] kind,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic ovf,
                                         input logic [NUM_KW-1:0] kw,
                                         input logic [LINE_W-1:0] line,
                                         input logic [LINE_W-1:0] scol);
      cmd_type r;
      logic hit;
      logic [4:0] kk;
      hit = 1'b0;
      kk = kind;
      if (kind == KIND_IDENT && !ovf) begin
         for (int k = 0; k < NUM_KW; k++) begin
            if (!hit && kw[k] && cnt == KW_LEN[k]) begin
               hit = 1'b1;
               kk = KIND_FN + 5'(k);
            end
         end
      end
      if (hit) begin
         r = make_single(kk, line, scol, '0, 8'h00, 1'b0);
      end else if (cnt == '0) begin
         r = make_single(kind, line, scol, '0, 8'h00, ovf);
      end else begin
         r = make_single(kind, line, scol, cnt, 8'h00, ovf);
         r.op = CMD_TEXT;
      end
      return r;
   endfunction

   assign req_stall  = |pend_ff;
   assign req_accept = req_valid && !req_stall;
   assign push_valid = |pend_ff;
   assign push_data  = pend_ff[0] ? slot_ff[0] : (pend_ff[1] ? slot_ff[1] : slot_ff[2]);

   always_comb begin
      logic [7:0] c;
      logic       eoi;
      logic       ending;
      logic       do_append;
      logic [4:0] end_kind;
      punct_type  pl;
      cmd_type    s0, s1, s2;
      logic [2:0] v;
      logic [2:0] o;

      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      line_in = line_ff;
      col_in  = col_ff;
      scol_in = scol_ff;
      kw_in   = kw_ff;
      slot_in = slot_ff;
      pend_in = pend_ff;

      c = req_data.char_code;
      eoi = req_data.end_of_input;
      pl = punct_lookup(c);
      s0 = '0;
      s1 = '0;
      s2 = '0;
      v = 3'b000;
      o = 3'b000;
      do_append = 1'b0;
      end_kind = (mode_ff == MODE_INT) ? KIND_INT :
                 (mode_ff == MODE_STRING) ? KIND_STRING : KIND_IDENT;
      ending = (mode_ff == MODE_IDENT && !(is_alpha(c) || is_digit(c))) ||
               (mode_ff == MODE_INT && !is_digit(c)) ||
               (mode_ff == MODE_STRING && c == CH_QUOTE);

      if (req_accept) begin
         if (ending) begin
            s0 = make_emit(end_kind, cnt_ff, ovf_ff, kw_ff, line_ff, scol_ff);
            v[0] = 1'b1;
            mode_in = MODE_IDLE;
            if (mode_ff == MODE_STRING) begin
               col_in = sat_inc(col_in);
            end
         end

         if (mode_ff == MODE_IDLE || (ending && mode_ff != MODE_STRING)) begin
            if (pl.hit) begin
               s1 = make_single(pl.kind, line_in, col_in, '0, 8'h00, 1'b0);
               v[1] = 1'b1;
               col_in = sat_inc(col_in);
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_STRING;
               scol_in = col_in;
               cnt_in = '0;
               ovf_in = 1'b0;
               col_in = sat_inc(col_in);
            end else if (c == CH_SPACE) begin
               col_in = sat_inc(col_in);
            end else if (c == CH_NL) begin
               line_in = sat_inc(line_in);
               col_in = '0;
            end else if (c == CH_TAB) begin
               s1 = make_single(KIND_TAB, line_in, col_in, '0, 8'h00, 1'b0);
               v[1] = 1'b1;
               col_in = sat_inc(col_in);
            end else if (is_alpha(c) || is_digit(c)) begin
               mode_in = is_alpha(c) ? MODE_IDENT : MODE_INT;
               scol_in = col_in;
               cnt_in = '0;
               ovf_in = 1'b0;
               kw_in = '1;
               do_append = 1'b1;
            end else begin
               s1 = make_single(KIND_UNKNOWN, line_in, col_in, CNT_W'(1), c, 1'b0);
               v[1] = 1'b1;
               col_in = sat_inc(col_in);
            end
         end else if (!ending) begin
            do_append = 1'b1;
         end

         if (do_append) begin
            if (cnt_in < CNT_W'(MAX_TEXT)) begin
               s1.op = CMD_APPEND;
               s1.res = '0;
               s1.res.text_byte = c;
               s1.res.text_length = cnt_in;
               v[1] = 1'b1;
               for (int k = 0; k < NUM_KW; k++) begin
                  kw_in[k] = kw_in[k] && (cnt_in < KW_LEN[k]) &&
                             (c == kw_char(2'(k), cnt_in[2:0]));
               end
               cnt_in = cnt_in + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            col_in = sat_inc(col_in);
         end

         if (eoi) begin
            if (mode_in == MODE_IDENT) begin
               s2 = make_emit(KIND_IDENT, cnt_in, ovf_in, kw_in, line_in, scol_in);
               v[2] = 1'b1;
            end else if (mode_in == MODE_INT) begin
               s2 = make_emit(KIND_INT, cnt_in, ovf_in, kw_in, line_in, scol_in);
               v[2] = 1'b1;
            end else if (mode_in == MODE_STRING) begin
               s2 = make_single(KIND_UNTERM, line_in, scol_in, '0, 8'h00, 1'b0);
               v[2] = 1'b1;
            end
            mode_in = MODE_IDLE;
            cnt_in = '0;
            ovf_in = 1'b0;
            line_in = '0;
            col_in = '0;
            scol_in = '0;
         end

         o[0] = v[0] && s0.op != CMD_APPEND;
         o[1] = v[1] && s1.op != CMD_APPEND;
         o[2] = v[2] && s2.op != CMD_APPEND;
         s0.res.run_last = o[0] && !o[1] && !o[2];
         s1.res.run_last = o[1] && !o[2];
         s2.res.run_last = o[2];
         slot_in[0] = s0;
         slot_in[1] = s1;
         slot_in[2] = s2;
         pend_in = v;
      end else if (push_valid && !push_full) begin
         // drop the lowest pending command
         pend_in = pend_ff & (pend_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         line_ff <= '0;
         col_ff  <= '0;
         scol_ff <= '0;
         kw_ff   <= '0;
         pend_ff <= 3'b000;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         scol_ff <= scol_in;
         kw_ff   <= kw_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   a_eoi_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_input |=>
      mode_ff == MODE_IDLE && line_ff == '0 && col_ff == '0)
      else $error("end of input did not restart the lexer");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> cnt_ff == CNT_W'(MAX_TEXT))
      else $error("overflow flagged with room left in the buffer");

   a_flush_slot: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_data.end_of_input |=> !pend_ff[2])
      else $error("flush command without end of input");

endmodule

// ----- rtl/stl_queue.sv -----
// ----------------------------------------------------------------------------
// stl_queue
// Short command queue between the classifier and the replay unit.
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_full,
   input  cmd_type push_data,
   output logic    head_valid,
   output cmd_type head_data,
   input  logic    pop
);

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_full  = count_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/stl_back.sv -----
// ----------------------------------------------------------------------------
// stl_back
// Holds the token text buffer, writes appended characters and replays
// buffered text one character per result through a registered output.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; #(
   parameter int unsigned MAX_TEXT = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

   logic [7:0]       text_mem [MAX_TEXT];
   logic [7:0]       rdata_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             stage_valid_ff, stage_valid_in;
   rsp_type          stage_ff, stage_in;
   logic             from_mem_ff, from_mem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_load;
   logic             stage_free;
   logic             wr_en;
   logic             rd_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic             last_char;

   assign out_load   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign stage_free = !stage_valid_ff || out_load;
   assign last_char  = (idx_ff + CNT_W'(1)) == head_data.res.text_length;
   assign wr_addr    = head_data.res.text_length[AW-1:0];
   assign rd_addr    = idx_ff[AW-1:0];
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      pop = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;
      idx_in = idx_ff;
      stage_in = stage_ff;
      from_mem_in = from_mem_ff;
      stage_valid_in = stage_valid_ff && !out_load;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;

      if (out_load) begin
         rsp_in = stage_ff;
         if (from_mem_ff) begin
            rsp_in.text_byte = rdata_ff;
         end
         rsp_valid_in = 1'b1;
      end

      if (head_valid) begin
         unique case (head_data.op)
            CMD_APPEND: begin
               wr_en = 1'b1;
               pop = 1'b1;
            end
            CMD_SINGLE: begin
               if (stage_free) begin
                  stage_in = head_data.res;
                  from_mem_in = 1'b0;
                  stage_valid_in = 1'b1;
                  pop = 1'b1;
               end
            end
            CMD_TEXT: begin
               if (stage_free) begin
                  rd_en = 1'b1;
                  stage_in = head_data.res;
                  stage_in.text_index = idx_ff[IDX_W-1:0];
                  stage_in.token_done = last_char;
                  stage_in.run_last = head_data.res.run_last && last_char;
                  from_mem_in = 1'b1;
                  stage_valid_in = 1'b1;
                  if (last_char) begin
                     pop = 1'b1;
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      from_mem_ff <= from_mem_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_mem[wr_addr] <= head_data.res.text_byte;
      end
      if (rd_en) begin
         rdata_ff <= text_mem[rd_addr];
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid && head_data.op == CMD_TEXT |-> idx_ff < head_data.res.text_length)
      else $error("replay index past token text");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("replay index left over without a command");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.run_last |-> rsp_ff.token_done)
      else $error("run ended inside a token");

endmodule

// ----- bench/tb_source_token_lexer.sv -----
// ----------------------------------------------------------------------------
// tb_source_token_lexer
// Self-checking bench for the streaming source lexer. Source bytes go in as
// requests with random gaps. A scoreboard class keeps its own lexer state,
// predicts every token result, and compares arriving results field by field.
// The run covers all punctuation, the keywords, identifiers, integers,
// strings, tabs, unknown bytes, end-of-input flushes, truncated text, and a
// long result-side hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_source_token_lexer import stl_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TEXT_MAX   = 32;
   localparam int unsigned HOLD_LEN   = 400;
   localparam int unsigned RAND_BYTES = 120;
   localparam int unsigned DRAIN_WAIT = 24;

   localparam logic [4:0] KIND_PUNCT_FIRST = 5'd0;
   localparam logic [4:0] KIND_EXTERN      = 5'd12;
   localparam logic [4:0] KIND_VAR         = 5'd13;
   localparam logic [4:0] KIND_STRUCT      = 5'd14;

   localparam logic [7:0] PUNCT_CHARS [10] = '{"(", ")", "{", "}", "=", ":", ",", ".",
                                               "<", ">"};

   class token_scoreboard;
      mode_type    mode;
      logic [7:0]  text [TEXT_MAX];
      int unsigned text_cnt;
      logic        text_cut;
      logic [15:0] line_no;
      logic [15:0] col_no;
      logic [15:0] tok_col;
      rsp_type     step_out [$];
      rsp_type     due_tokens [$];
      int unsigned mismatches;
      int unsigned bytes_seen;
      int unsigned results_seen;
      int unsigned tokens_seen;

      function new();
         mode = MODE_IDLE;
         foreach (text[i]) text[i] = 8'h00;
         text_cnt = 0;
         text_cut = 1'b0;
         line_no = '0;
         col_no = '0;
         tok_col = '0;
         mismatches = 0;
         bytes_seen = 0;
         results_seen = 0;
         tokens_seen = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function logic letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function logic numeral(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function void add_result(logic [4:0] kind, logic [15:0] col, logic [5:0] len,
                               logic [7:0] b, logic [4:0] idx, logic cut, logic done);
         rsp_type r;
         r.token_kind = kind;
         r.line_number = line_no;
         r.column_number = col;
         r.text_length = len;
         r.text_byte = b;
         r.text_index = idx;
         r.text_truncated = cut;
         r.token_done = done;
         r.run_last = 1'b0;
         step_out = {step_out, r};
      endfunction

      function void take_char(logic [7:0] c);
         if (text_cnt < TEXT_MAX) begin
            text[text_cnt] = c;
            text_cnt++;
         end else begin
            text_cut = 1'b1;
         end
         col_no = bump(col_no);
      endfunction

      function void open_text(mode_type m);
         mode = m;
         tok_col = col_no;
         text_cnt = 0;
         text_cut = 1'b0;
      endfunction

      function logic [4:0] keyword_kind();
         logic [47:0] w;
         w = {text[0], text[1], text[2], text[3], text[4], text[5]};
         if (text_cut) return KIND_IDENT;
         if (text_cnt == 2 && w[47:32] == "fn") return KIND_FN;
         if (text_cnt == 6 && w == "extern") return KIND_EXTERN;
         if (text_cnt == 3 && w[47:24] == "var") return KIND_VAR;
         if (text_cnt == 6 && w == "struct") return KIND_STRUCT;
         return KIND_IDENT;
      endfunction

      function void flush_text(logic [4:0] kind);
         logic [4:0] k;
         k = (kind == KIND_IDENT) ? keyword_kind() : kind;
         if (k != kind) begin
            add_result(k, tok_col, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
         end else if (text_cnt == 0) begin
            add_result(kind, tok_col, 6'd0, 8'h00, 5'd0, text_cut, 1'b1);
         end else begin
            for (int i = 0; i < text_cnt; i++)
               add_result(kind, tok_col, 6'(text_cnt), text[i], 5'(i), text_cut,
                          i + 1 == text_cnt);
         end
      endfunction

      function void idle_byte(logic [7:0] c);
         for (int i = 0; i < 10; i++) begin
            if (c == PUNCT_CHARS[i]) begin
               add_result(5'(KIND_PUNCT_FIRST + i), col_no, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
               col_no = bump(col_no);
               return;
            end
         end
         if (c == CH_QUOTE) begin
            open_text(MODE_STRING);
            col_no = bump(col_no);
         end else if (c == CH_SPACE) begin
            col_no = bump(col_no);
         end else if (c == CH_NL) begin
            line_no = bump(line_no);
            col_no = '0;
         end else if (c == CH_TAB) begin
            add_result(KIND_TAB, col_no, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
            col_no = bump(col_no);
         end else if (letter(c)) begin
            open_text(MODE_IDENT);
            take_char(c);
         end else if (numeral(c)) begin
            open_text(MODE_INT);
            take_char(c);
         end else begin
            add_result(KIND_UNKNOWN, col_no, 6'd1, c, 5'd0, 1'b0, 1'b1);
            col_no = bump(col_no);
         end
      endfunction

      function void note_request(req_type r);
         logic [7:0] c;
         rsp_type    t;
         c = r.char_code;
         step_out.delete();
         bytes_seen++;
         case (mode)
            MODE_IDENT: begin
               if (letter(c) || numeral(c)) begin
                  take_char(c);
               end else begin
                  flush_text(KIND_IDENT);
                  mode = MODE_IDLE;
                  idle_byte(c);
               end
            end
            MODE_INT: begin
               if (numeral(c)) begin
                  take_char(c);
               end else begin
                  flush_text(KIND_INT);
                  mode = MODE_IDLE;
                  idle_byte(c);
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  flush_text(KIND_STRING);
                  col_no = bump(col_no);
                  mode = MODE_IDLE;
               end else begin
                  take_char(c);
               end
            end
            default: idle_byte(c);
         endcase
         if (r.end_of_input) begin
            if (mode == MODE_IDENT) flush_text(KIND_IDENT);
            else if (mode == MODE_INT) flush_text(KIND_INT);
            else if (mode == MODE_STRING)
               add_result(KIND_UNTERM, tok_col, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1);
            mode = MODE_IDLE;
            text_cnt = 0;
            text_cut = 1'b0;
            line_no = '0;
            col_no = '0;
            tok_col = '0;
         end
         if (step_out.size() > 0) begin
            t = step_out.pop_back();
            t.run_last = 1'b1;
            step_out = {step_out, t};
         end
         due_tokens = {due_tokens, step_out};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (due_tokens.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = due_tokens.pop_front();
         if (got.token_done === 1'b1) tokens_seen++;
         compare_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
         compare_field("line_number", 32'(want.line_number), 32'(got.line_number));
         compare_field("column_number", 32'(want.column_number), 32'(got.column_number));
         compare_field("text_length", 32'(want.text_length), 32'(got.text_length));
         compare_field("text_byte", 32'(want.text_byte), 32'(got.text_byte));
         compare_field("text_index", 32'(want.text_index), 32'(got.text_index));
         compare_field("text_truncated", 32'(want.text_truncated),
                       32'(got.text_truncated));
         compare_field("token_done", 32'(want.token_done), 32'(got.token_done));
         compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
      endfunction

      function int unsigned outstanding();
         return due_tokens.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic    calm = 1'b0;
   logic    hold_go = 1'b0;
   logic    rsp_hold = 1'b0;
   int unsigned rsp_wait = 0;

   token_scoreboard sb;
   logic [7:0] piece [$];
   string      keyword_text [4] = '{"fn", "extern", "var", "struct"};

   source_token_lexer #(.MAX_TEXT(TEXT_MAX)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   task automatic send_byte(input logic [7:0] c, input logic eoi);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(7, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {c, eoi};
      do @(posedge clock); while (req_stall);
      sb.note_request({c, eoi});
   endtask

   task automatic send_piece(input logic eoi_last);
      for (int i = 0; i < piece.size(); i++)
         send_byte(piece[i], eoi_last && (i == piece.size() - 1));
   endtask

   function automatic void queue_byte(input logic [7:0] b);
      piece = {piece, b};
   endfunction

   task automatic send_text(input string s, input logic eoi_last);
      piece.delete();
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
      send_piece(eoi_last);
   endtask

   function automatic logic [7:0] random_letter();
      int unsigned n;
      n = $urandom_range(51, 0);
      return (n < 26) ? 8'("a" + n) : 8'("A" + n - 26);
   endfunction

   // result side: check, then hold stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
            rsp_wait = calm ? 0 : $urandom_range(7, 0);
         end
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #18_000_000;
      $display("source_token_lexer regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned rand_bytes;
      int unsigned pick;
      int unsigned n;
      logic        eoi_last;
      logic [7:0]  c;
      string       w;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_text("(){}=:,.<>fn ", 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("\"\"9a", 1'b0);
      send_byte(CH_NL, 1'b0);
      send_text("\"\nx", 1'b1);

      hold_go <= 1'b1;
      rand_bytes = 0;
      while (rand_bytes < RAND_BYTES) begin
         if ($urandom_range(11, 0) == 0) calm <= ~calm;
         piece.delete();
         eoi_last = 1'b0;
         pick = $urandom_range(99, 0);
         if (pick < 15) begin
            queue_byte(PUNCT_CHARS[$urandom_range(9, 0)]);
         end else if (pick < 25) begin
            w = keyword_text[$urandom_range(3, 0)];
            for (int i = 0; i < w.len(); i++) queue_byte(w[i]);
            queue_byte(CH_SPACE);
         end else if (pick < 40) begin
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 30) : $urandom_range(6, 1);
            queue_byte(random_letter());
            for (int i = 1; i < n; i++)
               queue_byte($urandom_range(2, 0) == 0 ? 8'("0" + $urandom_range(9, 0))
                                                    : random_letter());
         end else if (pick < 50) begin
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(36, 33) : $urandom_range(5, 1);
            for (int i = 0; i < n; i++) queue_byte(8'("0" + $urandom_range(9, 0)));
         end else if (pick < 62) begin
            n = ($urandom_range(9, 0) == 0) ? 34 : $urandom_range(6, 0);
            eoi_last = ($urandom_range(5, 0) == 0);
            queue_byte(CH_QUOTE);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(5, 0) == 0) begin
                  c = CH_NL;
               end else begin
                  do c = 8'($urandom_range(255, 0)); while (c == CH_QUOTE);
               end
               queue_byte(c);
            end
            if (!eoi_last) queue_byte(CH_QUOTE);
         end else if (pick < 75) begin
            queue_byte(CH_SPACE);
         end else if (pick < 81) begin
            queue_byte(CH_NL);
         end else if (pick < 85) begin
            queue_byte(CH_TAB);
         end else if (pick < 93) begin
            queue_byte(8'($urandom_range(255, 0)));
         end else begin
            queue_byte(8'($urandom_range(255, 0)));
            eoi_last = 1'b1;
         end
         send_piece(eoi_last);
         rand_bytes += piece.size();
      end

      send_text("(ab 7\t\"q", 1'b1);
      calm <= 1'b0;
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Lexed %0d source bytes into %0d results over %0d tokens.",
               sb.bytes_seen, sb.results_seen, sb.tokens_seen);
      $display("Included long result hold, truncated text and end-of-input flushes.");
      if (sb.mismatches == 0) begin
         $display("source_token_lexer regression: pass");
      end else begin
         $display("source_token_lexer regression: fail");
      end
      $finish;
   end

endmodule

// ----- source_token_lexer.f -----
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/source_token_lexer.sv
bench/tb_source_token_lexer.sv
